@@ src/pixel_format_to_rgb8_top_defines.svh @@
// ----------------------------------------------------------------------------
// Pixel format to RGB8 - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_TO_RGB8_TOP_DEFINES_SVH
`define PIXEL_FORMAT_TO_RGB8_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PFTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PFTR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/pftr_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel format to RGB8 - package
// Payload structs, configuration codes and constants shared by the block.
// ----------------------------------------------------------------------------
package pftr_pkg;

    localparam int NUM_LANES = 4;

    // Source format codes; unlisted codes decode as R8G8B8A8
    typedef enum logic [4:0] {
        FMT_R8G8B8      = 5'd0,
        FMT_R8G8B8A8    = 5'd1,
        FMT_B8G8R8A8    = 5'd2,
        FMT_B8G8R8X8    = 5'd3,
        FMT_A8R8G8B8    = 5'd4,
        FMT_X8R8G8B8    = 5'd5,
        FMT_A2R10G10B10 = 5'd6,
        FMT_A2B10G10R10 = 5'd7,
        FMT_R10G10B10A2 = 5'd8,
        FMT_R5G6B5      = 5'd9,
        FMT_B5G6R5      = 5'd10,
        FMT_A1R5G5B5    = 5'd11,
        FMT_X1R5G5B5    = 5'd12,
        FMT_B5G5R5A1    = 5'd13,
        FMT_RGBA_HALF   = 5'd14,
        FMT_RGBA_UNORM16 = 5'd15,
        FMT_RGBA_FLOAT  = 5'd16,
        FMT_RGBA8       = 5'd17
    } t_src_fmt;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SOURCE_FORMAT = 2'd0,
        REG_OUT_CHANNELS  = 2'd1,
        REG_FORCE_OPAQUE  = 2'd2
    } t_cfg_reg;

    localparam logic [2:0] BYTES_RGB  = 3'd3;
    localparam logic [2:0] BYTES_RGBA = 3'd4;

    typedef struct packed {
        logic [63:0] pixel_low;
        logic [63:0] pixel_high;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [2:0] byte_count;
    } t_pixel_out;

    typedef struct packed {
        t_src_fmt   source_format;
        logic [2:0] out_channels;
        logic       force_opaque;
    } t_cfg;

endpackage

@@ src/pftr_f32_to_u8.sv @@
// ----------------------------------------------------------------------------
// Pixel format to RGB8 - float lane
// Clamps a single-precision value to 0..1 and scales it by 255 with
// round-to-nearest-even at 24 bits, then truncates to a byte.
// ----------------------------------------------------------------------------
module pftr_f32_to_u8 (
    input  logic [31:0] i_word,
    output logic [7:0]  o_byte
);
    logic        sign;
    logic [7:0]  expo;
    logic [22:0] mant;
    logic [23:0] sig;
    logic [31:0] prod;
    logic        wide;
    logic [24:0] q;
    logic [7:0]  rem;
    logic [7:0]  half;
    logic        round_up;
    logic [24:0] q_rnd;
    logic [7:0]  sh_full;
    logic [4:0]  sh;
    logic [24:0] scaled;

    assign sign = i_word[31];
    assign expo = i_word[30:23];
    assign mant = i_word[22:0];
    assign sig  = {1'b1, mant};

    // sig * 255 as one subtract
    assign prod = {sig, 8'd0} - {8'd0, sig};
    assign wide = prod[31];

    // round the product to 24 significant bits
    assign q        = wide ? {1'b0, prod[31:8]} : {1'b0, prod[30:7]};
    assign rem      = wide ? prod[7:0] : {1'b0, prod[6:0]};
    assign half     = wide ? 8'h80 : 8'h40;
    assign round_up = (rem > half) || ((rem == half) && q[0]);
    assign q_rnd    = q + {24'd0, round_up};

    // align to the binary point: shift lies in 16..24 for exponents 119..126
    assign sh_full = (wide ? 8'd142 : 8'd143) - expo;
    assign sh      = sh_full[4:0];
    assign scaled  = q_rnd >> sh;

    // pick out the special ranges before the scaled path
    always_comb begin
        if (expo == 8'hFF) begin
            o_byte = ((mant != 23'd0) || sign) ? 8'd0 : 8'd255;
        end else if (sign) begin
            o_byte = 8'd0;
        end else if (expo >= 8'd127) begin
            o_byte = 8'd255;
        end else if (expo <= 8'd118) begin
            o_byte = 8'd0;
        end else begin
            o_byte = scaled[7:0];
        end
    end

endmodule

@@ src/pftr_decode.sv @@
// ----------------------------------------------------------------------------
// Pixel format to RGB8 - format decoder
// Selects and reduces the channels of one source pixel per the configured
// format, applies the alpha policy and the output byte count.
// ----------------------------------------------------------------------------
module pftr_decode (
    input  pftr_pkg::t_cfg       i_cfg,
    input  pftr_pkg::t_pixel_in  i_pixel,
    output pftr_pkg::t_pixel_out o_result
);
    import pftr_pkg::*;

    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] w32;
    logic [15:0] w16;
    logic [31:0] lane_in  [NUM_LANES];
    logic [7:0]  lane_out [NUM_LANES];
    logic [7:0]  r, g, b, a;

    assign lo  = i_pixel.pixel_low;
    assign hi  = i_pixel.pixel_high;
    assign w32 = lo[31:0];
    assign w16 = lo[15:0];

    // Feed each float lane: half values widen to single, keeping sign,
    // zero and infinity/NaN classes; denormal halves convert to a zero byte.
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        logic [15:0] hv;
        logic [4:0]  he;
        logic [7:0]  se;
        logic [31:0] sw;

        assign hv = lo[16*i +: 16];
        assign he = hv[14:10];
        assign sw = (i < 2) ? lo[32*(i%2) +: 32] : hi[32*(i%2) +: 32];

        always_comb begin
            if (he == 5'd0) begin
                se = 8'd0;
            end else if (he == 5'h1F) begin
                se = 8'hFF;
            end else begin
                se = {3'd0, he} + 8'd112;
            end
        end

        assign lane_in[i] = (i_cfg.source_format == FMT_RGBA_HALF)
                          ? {hv[15], se, hv[9:0], 13'd0} : sw;

        pftr_f32_to_u8 u_lane (
            .i_word (lane_in[i]),
            .o_byte (lane_out[i])
        );
    end

    // Channel selection per source format
    always_comb begin
        r = lo[7:0];
        g = lo[15:8];
        b = lo[23:16];
        a = 8'd255;
        case (i_cfg.source_format)
            FMT_R8G8B8: begin
                r = lo[7:0];  g = lo[15:8];  b = lo[23:16];
            end
            FMT_B8G8R8A8, FMT_A8R8G8B8: begin
                b = lo[7:0];  g = lo[15:8];  r = lo[23:16]; a = lo[31:24];
            end
            FMT_B8G8R8X8, FMT_X8R8G8B8: begin
                b = lo[7:0];  g = lo[15:8];  r = lo[23:16];
            end
            FMT_A2R10G10B10: begin
                b = w32[9:2]; g = w32[19:12]; r = w32[29:22];
                a = {4{w32[31:30]}};
            end
            FMT_A2B10G10R10, FMT_R10G10B10A2: begin
                r = w32[9:2]; g = w32[19:12]; b = w32[29:22];
                a = {4{w32[31:30]}};
            end
            FMT_R5G6B5: begin
                r = {w16[15:11], 3'd0}; g = {w16[10:5], 2'd0}; b = {w16[4:0], 3'd0};
            end
            FMT_B5G6R5: begin
                b = {w16[15:11], 3'd0}; g = {w16[10:5], 2'd0}; r = {w16[4:0], 3'd0};
            end
            FMT_A1R5G5B5: begin
                b = {w16[4:0], 3'd0}; g = {w16[9:5], 3'd0}; r = {w16[14:10], 3'd0};
                a = {8{w16[15]}};
            end
            FMT_X1R5G5B5: begin
                b = {w16[4:0], 3'd0}; g = {w16[9:5], 3'd0}; r = {w16[14:10], 3'd0};
            end
            FMT_B5G5R5A1: begin
                a = {8{w16[0]}};
                r = {w16[5:1], 3'd0}; g = {w16[10:6], 3'd0}; b = {w16[15:11], 3'd0};
            end
            FMT_RGBA_HALF, FMT_RGBA_FLOAT: begin
                r = lane_out[0]; g = lane_out[1]; b = lane_out[2]; a = lane_out[3];
            end
            FMT_RGBA_UNORM16: begin
                r = lo[15:8]; g = lo[31:24]; b = lo[47:40]; a = lo[63:56];
            end
            default: begin
                r = lo[7:0];  g = lo[15:8];  b = lo[23:16]; a = lo[31:24];
            end
        endcase
    end

    // Alpha policy and stored byte count
    always_comb begin
        o_result.red   = r;
        o_result.green = g;
        o_result.blue  = b;
        if (i_cfg.out_channels == BYTES_RGB) begin
            o_result.byte_count = BYTES_RGB;
            o_result.alpha      = 8'd0;
        end else begin
            o_result.byte_count = BYTES_RGBA;
            o_result.alpha      = i_cfg.force_opaque ? 8'd255 : a;
        end
    end

endmodule

@@ src/pixel_format_to_rgb8_top.sv @@
// ----------------------------------------------------------------------------
// Pixel format to RGB8 - top level
// Converts one raw source pixel per clock into 8-bit RGB or RGBA.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge with start high; busy stays low, so a
// new pixel may follow in the very next cycle without limit. Each pixel gives
// exactly one result, shown for one cycle with o_strobe: the pixel is held in
// the input register, then passes the format decoder and float lanes into the
// result register. The receiver has no way to stall and must take every
// strobed result. Configuration writes are always ready and should be made
// only while no pixel is in flight.
module pixel_format_to_rgb8_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pftr_pkg::t_pixel_in  i_pixel,
    output logic                 o_strobe,
    output pftr_pkg::t_pixel_out o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [4:0]           i_cfg_data
);
    import pftr_pkg::*;

    logic       r_in_valid;
    t_pixel_in  r_pixel;
    logic       r_out_valid;
    t_pixel_out r_result;
    t_cfg       r_cfg;
    t_pixel_out n_result;
    logic       accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_format <= FMT_R8G8B8A8;
            r_cfg.out_channels  <= BYTES_RGBA;
            r_cfg.force_opaque  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SOURCE_FORMAT: r_cfg.source_format <= t_src_fmt'(i_cfg_data);
                REG_OUT_CHANNELS:  r_cfg.out_channels  <= i_cfg_data[2:0];
                REG_FORCE_OPAQUE:  r_cfg.force_opaque  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input stage: capture the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel <= i_pixel;
        end
    end

    pftr_decode u_decode (
        .i_cfg    (r_cfg),
        .i_pixel  (r_pixel),
        .o_result (n_result)
    );

    // Result stage: hold the converted pixel for one strobe cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_result;

`include "pixel_format_to_rgb8_top_defines.svh"

    `PFTR_ASSERT_NEXT(a_accept_loads, accept, r_in_valid, "accepted pixel not captured")
    `PFTR_ASSERT_NEXT(a_result_follows, r_in_valid, o_strobe, "captured pixel gave no result")
    `PFTR_ASSERT_SAME(a_count_legal, o_strobe,
        (o_result.byte_count == BYTES_RGB) || (o_result.byte_count == BYTES_RGBA),
        "byte count out of range")
    `PFTR_ASSERT_SAME(a_rgb_alpha_zero, o_strobe && (o_result.byte_count == BYTES_RGB),
        o_result.alpha == 8'd0, "alpha not cleared for three-byte result")

endmodule

@@ tb/tb_pixel_format_to_rgb8_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel format to RGB8 - testbench
// Drives raw source pixels through every source format, channel count and
// alpha mode, predicts each 8-bit RGBA result locally, and compares every
// strobed result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_pixel_format_to_rgb8_top;

    import pftr_pkg::*;

    localparam int QUIET_LIMIT    = 2000;
    localparam int NUM_PHASES     = 40;
    localparam int PIXELS_PER_SET = 37;

    // Holds the configuration copy and the queue of predicted pixels
    class rgb8_scoreboard;
        logic [4:0]  fmt      = FMT_R8G8B8A8;
        logic [2:0]  channels = BYTES_RGBA;
        logic        opaque   = 1'b1;
        t_pixel_out  expected_q[$];
        int          errors   = 0;

        function void set_reg(t_cfg_reg idx, logic [4:0] val);
            case (idx)
                REG_SOURCE_FORMAT: fmt      = val;
                REG_OUT_CHANNELS:  channels = val[2:0];
                REG_FORCE_OPAQUE:  opaque   = val[0];
                default: ;
            endcase
        endfunction

        // Clamp a single float to 0..1, scale by 255 with round-to-nearest-even,
        // then truncate
        function logic [7:0] single_to_byte(logic [31:0] f);
            logic [7:0]  ex;
            logic [63:0] prod;
            logic [63:0] quo;
            logic [63:0] rem;
            logic [63:0] halfw;
            int          d;
            int          sh;
            ex = f[30:23];
            if (ex == 8'hFF) return (f[22:0] != 0 || f[31]) ? 8'd0 : 8'd255;
            if (f[31]) return 8'd0;
            if (ex >= 8'd127) return 8'd255;
            if (ex <= 8'd118) return 8'd0;
            prod  = 64'({1'b1, f[22:0]}) * 64'd255;
            d     = (prod >= 64'h8000_0000) ? 8 : 7;
            quo   = prod >> d;
            rem   = prod & ((64'd1 << d) - 64'd1);
            halfw = 64'd1 << (d - 1);
            if (rem > halfw || (rem == halfw && quo[0])) quo = quo + 64'd1;
            sh = 150 - int'(ex) - d;
            quo = quo >> sh;
            return quo[7:0];
        endfunction

        // Drop negatives, denormals and NaN; widen the rest to single
        function logic [7:0] half_to_byte(logic [15:0] h);
            logic [4:0] ex;
            ex = h[14:10];
            if (h[15] || ex == 5'd0) return 8'd0;
            if (ex == 5'd31) return (h[9:0] != 0) ? 8'd0 : 8'd255;
            return single_to_byte({1'b0, 8'(int'(ex) + 112), h[9:0], 13'd0});
        endfunction

        function t_pixel_out convert_pixel(t_pixel_in p);
            logic [63:0] lo;
            logic [63:0] hi;
            logic [31:0] w32;
            logic [15:0] w16;
            logic [7:0]  r;
            logic [7:0]  g;
            logic [7:0]  b;
            logic [7:0]  a;
            t_pixel_out  res;
            lo  = p.pixel_low;
            hi  = p.pixel_high;
            w32 = lo[31:0];
            w16 = lo[15:0];
            a   = 8'd255;
            case (fmt)
                FMT_R8G8B8: begin
                    {b, g, r} = lo[23:0];
                end
                FMT_B8G8R8A8, FMT_A8R8G8B8: begin
                    {a, r, g, b} = lo[31:0];
                end
                FMT_B8G8R8X8, FMT_X8R8G8B8: begin
                    {r, g, b} = lo[23:0];
                end
                FMT_A2R10G10B10: begin
                    b = w32[9:2];
                    g = w32[19:12];
                    r = w32[29:22];
                    a = 8'd85 * {6'd0, w32[31:30]};
                end
                FMT_A2B10G10R10, FMT_R10G10B10A2: begin
                    r = w32[9:2];
                    g = w32[19:12];
                    b = w32[29:22];
                    a = 8'd85 * {6'd0, w32[31:30]};
                end
                FMT_R5G6B5: begin
                    r = {w16[15:11], 3'd0};
                    g = {w16[10:5], 2'd0};
                    b = {w16[4:0], 3'd0};
                end
                FMT_B5G6R5: begin
                    b = {w16[15:11], 3'd0};
                    g = {w16[10:5], 2'd0};
                    r = {w16[4:0], 3'd0};
                end
                FMT_A1R5G5B5, FMT_X1R5G5B5: begin
                    b = {w16[4:0], 3'd0};
                    g = {w16[9:5], 3'd0};
                    r = {w16[14:10], 3'd0};
                    if (fmt == FMT_A1R5G5B5) a = w16[15] ? 8'd255 : 8'd0;
                end
                FMT_B5G5R5A1: begin
                    a = w16[0] ? 8'd255 : 8'd0;
                    r = {w16[5:1], 3'd0};
                    g = {w16[10:6], 3'd0};
                    b = {w16[15:11], 3'd0};
                end
                FMT_RGBA_HALF: begin
                    r = half_to_byte(lo[15:0]);
                    g = half_to_byte(lo[31:16]);
                    b = half_to_byte(lo[47:32]);
                    a = half_to_byte(lo[63:48]);
                end
                FMT_RGBA_UNORM16: begin
                    r = lo[15:8];
                    g = lo[31:24];
                    b = lo[47:40];
                    a = lo[63:56];
                end
                FMT_RGBA_FLOAT: begin
                    r = single_to_byte(lo[31:0]);
                    g = single_to_byte(lo[63:32]);
                    b = single_to_byte(hi[31:0]);
                    a = single_to_byte(hi[63:32]);
                end
                // R8G8B8A8, RGBA8 and every unknown code
                default: begin
                    {a, b, g, r} = lo[31:0];
                end
            endcase
            if (opaque) a = 8'd255;
            res.byte_count = (channels == BYTES_RGB) ? BYTES_RGB : BYTES_RGBA;
            if (channels == BYTES_RGB) a = 8'd0;
            res.red   = r;
            res.green = g;
            res.blue  = b;
            res.alpha = a;
            return res;
        endfunction

        function void note_pixel(t_pixel_in p);
            expected_q.push_back(convert_pixel(p));
        endfunction

        function void compare_field(string fld, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_pixel_out got);
            t_pixel_out want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no pixel pending: actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("byte_count", want.byte_count, got.byte_count);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_pixel_in   i_pixel     = '0;
    logic        o_strobe;
    t_pixel_out  o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [4:0]  i_cfg_data  = '0;

    rgb8_scoreboard sb = new();

    int pixels_taken    = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int setting_count   = 0;
    int quiet_cycles    = 0;

    pixel_format_to_rgb8_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel     (i_pixel),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Check results, note accepted pixels, and watch for a stalled block
    always @(posedge i_clk) begin
        logic moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_result(o_result);
                results_checked++;
                moved = 1'b1;
            end
            if (start && !busy) begin
                sb.note_pixel(i_pixel);
                pixels_taken++;
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Present one pixel and hold it until taken; start stays high afterwards
    task automatic send_pixel(t_pixel_in p);
        start   <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_for(int n);
        start   <= 1'b0;
        i_pixel <= {$urandom, $urandom, $urandom, $urandom};
        repeat (n) @(posedge i_clk);
    endtask

    // Drain every pending result, then give the pipeline spare cycles
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [4:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        reg_writes++;
    endtask

    task automatic set_config(logic [4:0] fmt, logic [2:0] chans, logic opq);
        wait_idle();
        write_reg(REG_SOURCE_FORMAT, fmt);
        write_reg(REG_OUT_CHANNELS, {2'd0, chans});
        write_reg(REG_FORCE_OPAQUE, {4'd0, opq});
        i_cfg_valid <= 1'b0;
        setting_count++;
    endtask

    function automatic t_pixel_in make_pixel(logic [63:0] lo, logic [63:0] hi);
        t_pixel_in p;
        p.pixel_low  = lo;
        p.pixel_high = hi;
        return p;
    endfunction

    // Mostly values near 0..1 so the scaling path is exercised
    function automatic logic [15:0] rand_half_lane();
        if ($urandom_range(0, 9) < 7)
            return {($urandom_range(0, 7) == 0), 5'($urandom_range(5, 16)), 10'($urandom)};
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_single_lane();
        if ($urandom_range(0, 9) < 7)
            return {($urandom_range(0, 7) == 0), 8'($urandom_range(117, 128)), 23'($urandom)};
        return $urandom;
    endfunction

    function automatic t_pixel_in random_pixel(logic [4:0] fmt);
        if (fmt == FMT_RGBA_HALF && $urandom_range(0, 3) != 0)
            return make_pixel({rand_half_lane(), rand_half_lane(), rand_half_lane(),
                               rand_half_lane()}, {$urandom, $urandom});
        if (fmt == FMT_RGBA_FLOAT && $urandom_range(0, 3) != 0)
            return make_pixel({rand_single_lane(), rand_single_lane()},
                              {rand_single_lane(), rand_single_lane()});
        return make_pixel({$urandom, $urandom}, {$urandom, $urandom});
    endfunction

    // Send a run of pixels in bursts with random gaps
    task automatic pixel_run(logic [4:0] fmt, int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            if (burst > left) burst = left;
            repeat (burst) send_pixel(random_pixel(fmt));
            left -= burst;
            if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
        end
    endtask

    initial begin
        logic [4:0] fmt;
        logic [2:0] chans;
        logic       opq;

        // Hold reset at start-up, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: R8G8B8A8, four bytes, opaque
        send_pixel(make_pixel(64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_pixel(make_pixel(64'hFFFF_FFFF_FFFF_FFFF, '0));

        // Decoded alpha visible
        set_config(FMT_R8G8B8A8, BYTES_RGBA, 1'b0);
        send_pixel(make_pixel('0, '0));
        send_pixel(make_pixel(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        set_config(FMT_A2R10G10B10, BYTES_RGBA, 1'b0);
        send_pixel(make_pixel(64'h0000_0000_C01F_F803, '0));
        set_config(FMT_A1R5G5B5, BYTES_RGBA, 1'b0);
        send_pixel(make_pixel(64'h8000, '0));
        send_pixel(make_pixel(64'h7FFF, '0));
        set_config(FMT_B5G5R5A1, BYTES_RGBA, 1'b0);
        send_pixel(make_pixel(64'h0001, '0));
        send_pixel(make_pixel(64'hFFFE, '0));

        // Half float: one, infinity, NaN, just below one, negatives, denormals
        set_config(FMT_RGBA_HALF, BYTES_RGBA, 1'b0);
        send_pixel(make_pixel(64'h3BFF_7E00_7C00_3C00, '0));
        send_pixel(make_pixel(64'h1C00_0001_BC00_3800, '0));
        send_pixel(make_pixel(64'h0000_8000_FC00_1BFF, '0));

        // Single float: one, infinity, NaN, negatives, the low edge of the scaled range, denormals
        set_config(FMT_RGBA_FLOAT, BYTES_RGBA, 1'b0);
        send_pixel(make_pixel(64'h7F80_0000_3F80_0000, 64'hBF80_0000_7FC0_0000));
        send_pixel(make_pixel(64'h3B80_0000_3F7F_FFFF, 64'h0000_0001_3B7F_FFFF));
        send_pixel(make_pixel(64'hFF80_0000_3F00_0000, 64'h8000_0000_0000_0000));

        // Unknown format code, and a channel count that falls back to four
        set_config(5'd31, 3'd7, 1'b0);
        send_pixel(make_pixel(64'hDEAD_BEEF_1234_5678, '0));
        set_config(FMT_RGBA_UNORM16, BYTES_RGB, 1'b0);
        send_pixel(make_pixel(64'hFFFF_0000_80FF_7F00, '0));

        // Random phases: every format first, then random settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 18) fmt = 5'(ph);
            else if (ph == 18) fmt = 5'd31;
            else if ($urandom_range(0, 7) == 0) fmt = 5'($urandom_range(18, 31));
            else fmt = 5'($urandom_range(0, 17));
            case (ph % 5)
                0: chans = BYTES_RGB;
                1: chans = BYTES_RGBA;
                2: chans = 3'd0;
                3: chans = 3'd7;
                default: chans = 3'($urandom_range(0, 7));
            endcase
            opq = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
            set_config(fmt, chans, opq);
            pixel_run(fmt, PIXELS_PER_SET);
        end

        // Drain and let the pipeline settle
        wait_idle();
        repeat (5) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, sb.pending());
            sb.errors++;
        end

        $display("Converted %0d pixels, checked %0d results across %0d settings",
                 pixels_taken, results_checked, setting_count);
        $display("(%0d register writes, %0d mismatches).", reg_writes, sb.errors);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/pftr_pkg.sv
src/pftr_f32_to_u8.sv
src/pftr_decode.sv
src/pixel_format_to_rgb8_top.sv
tb/tb_pixel_format_to_rgb8_top.sv
